// ----- src/brlt_pkg.sv -----
`default_nettype none
package brlt_pkg;

  localparam int DEF_LOCK_ENTRIES    = 16;
  localparam int DEF_OWNERS_PER_LOCK = 8;
  localparam int DEF_OFFSET_BITS     = 32;

  localparam int TYPE_W    = 2;
  localparam int OWNER_W   = 16;
  localparam int HANDLE_W  = 10;
  localparam int RANGE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int READERS_W = 8;
  localparam int COUNT_MAX = 31;

  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_UNLOCK = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_READ_E,
    OP_SKIP_E,
    OP_CHECK,
    OP_NEW,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_PACK_A,
    OP_PACK_B,
    OP_PACK_RD,
    OP_PACK_WR,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_LD,
    OP_SORT_CMP
  } brlt_op_t;

  typedef struct packed {
    brlt_op_t op;
  } brlt_cmd_t;

  typedef struct packed {
    logic early;
    logic is_unlock;
    logic e_end;
    logic e_valid;
    logic hit;
    logic split;
    logic pack_end;
    logic va;
    logic vb;
    logic sort_end;
    logic shift;
  } brlt_stat_t;

endpackage
`default_nettype wire

// ----- src/brlt_req_if.sv -----
`default_nettype none
interface brlt_req_if import brlt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [OWNER_W-1:0]  owner_id;
  logic [HANDLE_W-1:0] handle_id;
  logic [RANGE_W-1:0]  range_start;
  logic [RANGE_W-1:0]  range_length;

  modport source(output valid, req_type, owner_id, handle_id, range_start, range_length,
                 input ready);
  modport sink(input valid, req_type, owner_id, handle_id, range_start, range_length,
               output ready);
endinterface
`default_nettype wire

// ----- src/brlt_rsp_if.sv -----
`default_nettype none
interface brlt_rsp_if import brlt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entries_in_use;

  modport source(output valid, status, entries_in_use, input ready);
  modport sink(input valid, status, entries_in_use, output ready);
endinterface
`default_nettype wire

// ----- src/byte_range_lock_table.sv -----
// Byte-range lock table.
// Requests come in on req (valid/ready): read lock, write lock or unlock,
// with owner, handle and a byte range. Each request gives exactly one
// response on rsp: a status code and the count of entries in use after it.
// One request is worked on at a time; req.ready is high only while the
// controller is idle. A lock request walks the entry table in index order,
// skipping free entries and reading each valid entry from the RAM; the walk
// is left out when the owner is zero or the request is a no-op.
// An unlock that finds its entry adds a pack pass and an insertion sort,
// with LOCK_ENTRIES*(LOCK_ENTRIES-1)/2 shifts at worst. The entry RAM
// has a registered read port.
// Reset empties the table at once (valid bits in flops) and drops any
// pending response. The response is held in an output register until
// rsp.ready; the controller waits in its final state while that register
// is still full and unread.
`default_nettype none
module byte_range_lock_table import brlt_pkg::*; #(
  parameter int LOCK_ENTRIES    = DEF_LOCK_ENTRIES,
  parameter int OWNERS_PER_LOCK = DEF_OWNERS_PER_LOCK,
  parameter int OFFSET_BITS     = DEF_OFFSET_BITS
) (
  input wire logic   clk,
  input wire logic   rst,
  brlt_req_if.sink   req,
  brlt_rsp_if.source rsp
);

  brlt_cmd_t           cmd;
  brlt_stat_t          stat;
  logic                idle, finish, out_free, out_valid;
  logic [STATUS_W-1:0] res, out_status;
  logic [COUNT_W-1:0]  count, out_count;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = idle;

  brlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .finish   (finish)
  );

  brlt_dp #(
    .LOCK_ENTRIES    (LOCK_ENTRIES),
    .OWNERS_PER_LOCK (OWNERS_PER_LOCK),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_type   (req.req_type),
    .in_owner  (req.owner_id),
    .in_handle (req.handle_id),
    .in_start  (req.range_start),
    .in_length (req.range_length),
    .stat      (stat),
    .res       (res),
    .count     (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status <= res;
      out_count  <= count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.entries_in_use = out_count;

endmodule
`default_nettype wire

// ----- src/brlt_ram.sv -----
`default_nettype none
module brlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/brlt_dp.sv -----
`default_nettype none
module brlt_dp import brlt_pkg::*; #(
  parameter int LOCK_ENTRIES    = DEF_LOCK_ENTRIES,
  parameter int OWNERS_PER_LOCK = DEF_OWNERS_PER_LOCK,
  parameter int OFFSET_BITS     = DEF_OFFSET_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brlt_cmd_t           cmd,
  input  wire logic [TYPE_W-1:0]   in_type,
  input  wire logic [OWNER_W-1:0]  in_owner,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [RANGE_W-1:0]  in_start,
  input  wire logic [RANGE_W-1:0]  in_length,
  output brlt_stat_t               stat,
  output logic [STATUS_W-1:0]      res,
  output logic [COUNT_W-1:0]       count
);

  localparam int N     = LOCK_ENTRIES;
  localparam int OPL   = OWNERS_PER_LOCK;
  localparam int OB    = OFFSET_BITS;
  localparam int IW    = $clog2(N);
  localparam int EW    = $clog2(N + 1);
  localparam int KW    = (OPL > 1) ? $clog2(OPL) : 1;
  localparam int P_SZ  = OB;
  localparam int P_ISW = 2 * OB;
  localparam int P_RD  = 2 * OB + 1;
  localparam int P_HW  = P_RD + READERS_W;
  localparam int P_OWN = P_HW + 1;
  localparam int P_HND = P_OWN + OPL * OWNER_W;
  localparam int RW    = P_HND + OPL * HANDLE_W;

  logic [TYPE_W-1:0]   q_type;
  logic [OWNER_W-1:0]  q_own;
  logic [HANDLE_W-1:0] q_hnd;
  logic [OB-1:0]       q_s;
  logic [OB:0]         q_end;

  logic [N-1:0]  valid, valid_next;
  logic [EW-1:0] cnt, cnt_next;
  logic [EW-1:0] e, sa;
  logic [IW-1:0] pa, pb, p;
  logic [RW-1:0] rdata, cur, scratch, wdata;
  logic [IW-1:0] waddr, raddr;
  logic          we, inc, dec;

  logic [IW-1:0] e_idx, sa_idx, ff_idx, slot_base;
  logic          ff_ok;
  logic [OB:0]   q_s1, r_os1, r_oe, c_os1, c_oe;
  logic [OB-1:0] r_size, c_size;
  logic [READERS_W-1:0] r_rd, rd_inc;
  logic          overlap, contain, own_match, slot_free, hit, conflict;
  logic          mid, tstart, tend, end_ok, less;
  logic [KW-1:0] slot_idx;
  logic          is_unlock;

  brlt_ram #(.WIDTH(RW), .DEPTH(N)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e_idx     = e[IW-1:0];
  assign sa_idx    = sa[IW-1:0];
  assign slot_base = '0;
  assign is_unlock = (q_type == REQ_UNLOCK);
  assign q_s1      = {1'b0, q_s};
  assign r_os1     = {1'b0, rdata[OB-1:0]};
  assign r_size    = rdata[P_SZ +: OB];
  assign r_oe      = r_os1 + {1'b0, r_size};
  assign c_os1     = {1'b0, cur[OB-1:0]};
  assign c_size    = cur[P_SZ +: OB];
  assign c_oe      = c_os1 + {1'b0, c_size};
  assign r_rd      = rdata[P_RD +: READERS_W];
  assign rd_inc    = (r_rd == {READERS_W{1'b1}}) ? r_rd : r_rd + 1'b1;
  assign end_ok    = !q_end[OB];

  assign overlap  = (q_s1 < r_oe) && (q_end > r_os1);
  assign contain  = (q_s1 >= r_os1) && (q_end <= r_oe);
  assign conflict = (q_type == REQ_WRITE) || rdata[P_ISW];
  assign hit      = is_unlock ? (own_match && contain) : overlap;
  assign mid      = (q_s1 > r_os1) && (q_end < r_oe);
  assign tstart   = (q_s1 == r_os1) && (q_end < r_oe);
  assign tend     = (q_s1 > r_os1) && (q_end == r_oe);
  assign less     = (r_size < scratch[P_SZ +: OB]) ||
                    ((r_size == scratch[P_SZ +: OB]) && (rdata[OB-1:0] > scratch[OB-1:0]));

  // owner slots of the entry just read
  always_comb begin
    own_match = 1'b0;
    slot_free = 1'b0;
    slot_idx  = '0;
    for (int k = OPL - 1; k >= 0; k--) begin
      if (rdata[P_OWN + OWNER_W*k +: OWNER_W] == '0) begin
        slot_free = 1'b1;
        slot_idx  = KW'(k);
      end
    end
    for (int k = 0; k < OPL; k++) begin
      if (rdata[P_OWN + OWNER_W*k +: OWNER_W] == q_own &&
          rdata[P_HND + HANDLE_W*k +: HANDLE_W] == q_hnd) begin
        own_match = 1'b1;
      end
    end
  end

  always_comb begin
    ff_ok  = 1'b0;
    ff_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        ff_ok  = 1'b1;
        ff_idx = IW'(i);
      end
    end
  end

  always_comb begin
    we         = 1'b0;
    waddr      = e_idx;
    wdata      = rdata;
    raddr      = e_idx;
    valid_next = valid;
    inc        = 1'b0;
    dec        = 1'b0;
    case (cmd.op)
      OP_CHECK: begin
        if (hit && !is_unlock && !conflict) begin
          we = 1'b1;
          wdata[P_RD +: READERS_W] = rd_inc;
          if (slot_free) begin
            wdata[P_OWN + OWNER_W*int'(slot_idx) +: OWNER_W]    = q_own;
            wdata[P_HND + HANDLE_W*int'(slot_idx) +: HANDLE_W] = q_hnd;
          end
        end else if (hit && is_unlock && !mid) begin
          if (tstart && end_ok) begin
            we = 1'b1;
            wdata[OB-1:0]     = q_end[OB-1:0];
            wdata[P_SZ +: OB] = OB'(r_oe - q_end);
          end else if (tend) begin
            we = 1'b1;
            wdata[P_SZ +: OB] = OB'(q_s1 - r_os1);
          end else begin
            valid_next[e_idx] = 1'b0;
            dec = 1'b1;
          end
        end
      end
      OP_NEW: begin
        if (ff_ok) begin
          we    = 1'b1;
          waddr = ff_idx;
          wdata = '0;
          wdata[OB-1:0]     = q_s;
          wdata[P_SZ +: OB] = OB'(q_end - q_s1);
          wdata[P_ISW]      = (q_type == REQ_WRITE);
          wdata[P_RD +: READERS_W] = (q_type == REQ_WRITE) ? '0 : READERS_W'(1);
          wdata[P_HW]       = (q_type == REQ_WRITE);
          wdata[P_OWN +: OWNER_W]  = q_own;
          wdata[P_HND +: HANDLE_W] = q_hnd;
          valid_next[ff_idx] = 1'b1;
          inc = 1'b1;
        end
      end
      OP_SPLIT1: begin
        if (ff_ok) begin
          we    = 1'b1;
          waddr = ff_idx;
          wdata = cur;
          wdata[P_SZ +: OB] = OB'(q_s1 - c_os1);
          valid_next[ff_idx] = 1'b1;
          inc = 1'b1;
        end
      end
      OP_SPLIT2: begin
        valid_next[e_idx] = 1'b0;
        dec = 1'b1;
        if (ff_ok && end_ok) begin
          we    = 1'b1;
          waddr = ff_idx;
          wdata = cur;
          wdata[OB-1:0]     = q_end[OB-1:0];
          wdata[P_SZ +: OB] = OB'(c_oe - q_end);
          valid_next[ff_idx] = 1'b1;
          inc = 1'b1;
        end
      end
      OP_PACK_RD: raddr = pb;
      OP_PACK_WR: begin
        we    = 1'b1;
        waddr = pa;
        valid_next[pa] = 1'b1;
        valid_next[pb] = 1'b0;
      end
      OP_SORT_RD: raddr = sa_idx;
      OP_SORT_LD: raddr = sa_idx - 1'b1;
      OP_SORT_CMP: begin
        we    = 1'b1;
        waddr = p;
        if (p != slot_base && less) begin
          raddr = p - IW'(2);
        end else begin
          wdata = scratch;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case ({inc, dec})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cnt   <= '0;
      e     <= '0;
      sa    <= '0;
      pa    <= '0;
      pb    <= '0;
      p     <= '0;
      res   <= ST_DONE;
    end else begin
      valid <= valid_next;
      cnt   <= cnt_next;
      case (cmd.op)
        OP_LOAD: begin
          e <= '0;
          if (in_type == REQ_NONE) begin
            res <= ST_DONE;
          end else if (in_type == REQ_UNLOCK) begin
            res <= ST_NOT_FOUND;
          end else begin
            res <= ST_FULL;
          end
        end
        OP_SKIP_E: e <= e + 1'b1;
        OP_CHECK: begin
          if (!hit) begin
            e <= e + 1'b1;
          end else begin
            pa <= '0;
            pb <= IW'(N - 1);
            if (is_unlock) begin
              res <= ST_DONE;
            end else if (conflict) begin
              res <= ST_CONFLICT;
            end else begin
              res <= slot_free ? ST_DONE : ST_FULL;
            end
          end
        end
        OP_NEW: begin
          if (ff_ok) begin
            res <= ST_DONE;
          end
        end
        OP_PACK_A:    pa <= pa + 1'b1;
        OP_PACK_B:    pb <= pb - 1'b1;
        OP_SORT_INIT: sa <= EW'(1);
        OP_SORT_LD:   p  <= sa_idx;
        OP_SORT_CMP: begin
          if (p != slot_base && less) begin
            p <= p - 1'b1;
          end else begin
            sa <= sa + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request and held entries
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      q_type <= in_type;
      q_own  <= in_owner;
      q_hnd  <= in_handle;
      q_s    <= OB'(in_start);
      q_end  <= {1'b0, OB'(in_start)} + {1'b0, OB'(in_length)};
    end
    if (cmd.op == OP_CHECK) begin
      cur <= rdata;
    end
    if (cmd.op == OP_SORT_LD) begin
      scratch <= rdata;
    end
  end

  assign count = (32'(cnt) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt);

  assign stat.early     = (q_type == REQ_NONE) || (q_own == '0);
  assign stat.is_unlock = is_unlock;
  assign stat.e_end     = (e == EW'(N));
  assign stat.e_valid   = valid[e_idx];
  assign stat.hit       = hit;
  assign stat.split     = mid;
  assign stat.pack_end  = !(pa < pb);
  assign stat.va        = valid[pa];
  assign stat.vb        = valid[pb];
  assign stat.sort_end  = (sa == EW'(N)) || !valid[sa_idx];
  assign stat.shift     = (p != slot_base) && less;

endmodule
`default_nettype wire

// ----- src/brlt_ctrl.sv -----
`default_nettype none
module brlt_ctrl import brlt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       out_free,
  input  wire brlt_stat_t stat,
  output brlt_cmd_t       cmd,
  output logic            idle,
  output logic            finish
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_START    = 13'b0000000000010,
    S_SCAN     = 13'b0000000000100,
    S_CHK      = 13'b0000000001000,
    S_NEW      = 13'b0000000010000,
    S_SPLIT1   = 13'b0000000100000,
    S_SPLIT2   = 13'b0000001000000,
    S_PACK     = 13'b0000010000000,
    S_PACKWR   = 13'b0000100000000,
    S_SORTA    = 13'b0001000000000,
    S_SORTLD   = 13'b0010000000000,
    S_SORTCMP  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: state_next = stat.early ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (stat.e_end) begin
          state_next = stat.is_unlock ? S_DONE : S_NEW;
        end else if (stat.e_valid) begin
          cmd.op     = OP_READ_E;
          state_next = S_CHK;
        end else begin
          cmd.op = OP_SKIP_E;
        end
      end
      S_CHK: begin
        cmd.op = OP_CHECK;
        if (!stat.hit) begin
          state_next = S_SCAN;
        end else if (!stat.is_unlock) begin
          state_next = S_DONE;
        end else begin
          state_next = stat.split ? S_SPLIT1 : S_PACK;
        end
      end
      S_NEW: begin
        cmd.op     = OP_NEW;
        state_next = S_DONE;
      end
      S_SPLIT1: begin
        cmd.op     = OP_SPLIT1;
        state_next = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd.op     = OP_SPLIT2;
        state_next = S_PACK;
      end
      S_PACK: begin
        if (stat.pack_end) begin
          cmd.op     = OP_SORT_INIT;
          state_next = S_SORTA;
        end else if (stat.va) begin
          cmd.op = OP_PACK_A;
        end else if (!stat.vb) begin
          cmd.op = OP_PACK_B;
        end else begin
          cmd.op     = OP_PACK_RD;
          state_next = S_PACKWR;
        end
      end
      S_PACKWR: begin
        cmd.op     = OP_PACK_WR;
        state_next = S_PACK;
      end
      S_SORTA: begin
        if (stat.sort_end) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SORT_RD;
          state_next = S_SORTLD;
        end
      end
      S_SORTLD: begin
        cmd.op     = OP_SORT_LD;
        state_next = S_SORTCMP;
      end
      S_SORTCMP: begin
        cmd.op = OP_SORT_CMP;
        if (!stat.shift) begin
          state_next = S_SORTA;
        end
      end
      S_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
